>>> hdl/srfc_pkg.sv
// ----------------------------------------------------------------------------
// Solenoid and rumble feedback controller package
// Shared types, register codes, reset values and the ADC conversion function.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_pkg;

   // Widths of the configuration port and of the timing registers.
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned FlagsWidth    = 7;
   localparam int unsigned MsWidth       = 16;
   localparam int unsigned LevelWidth    = 8;
   localparam int unsigned TempWidth     = 10;
   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned AdcWidth      = 12;

   // Thermal sampling interval and default burst length.
   localparam int unsigned SampleIntervalMs  = 3;
   localparam int unsigned BurstShotsDefault = 3;

   // Feature flag bit positions.
   localparam int unsigned FlagSolenoid   = 0;
   localparam int unsigned FlagRumble     = 1;
   localparam int unsigned FlagRumbleFb   = 2;
   localparam int unsigned FlagAutofire   = 3;
   localparam int unsigned FlagBurst      = 4;
   localparam int unsigned FlagTempSensor = 5;
   localparam int unsigned FlagDoubleOff  = 6;

   // Register reset values.
   localparam logic [FlagsWidth-1:0] ResetFlags        = '0;
   localparam logic [MsWidth-1:0]    ResetSolenoidOn   = 16'd45;
   localparam logic [MsWidth-1:0]    ResetSolenoidOff  = 16'd80;
   localparam logic [MsWidth-1:0]    ResetSolenoidHold = 16'd500;
   localparam logic [MsWidth-1:0]    ResetRumbleLength = 16'd150;
   localparam logic [LevelWidth-1:0] ResetRumbleLevel  = 8'd255;
   localparam logic [TempWidth-1:0]  ResetTempWarning  = 10'd42;
   localparam logic [TempWidth-1:0]  ResetTempShutdown = 10'd50;

   // Hysteresis below each threshold, in degrees.
   localparam logic signed [TempWidth:0] Hysteresis = 11'sd5;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FEATURE_FLAGS   = 3'd0,
      CSR_SOLENOID_ON     = 3'd1,
      CSR_SOLENOID_OFF    = 3'd2,
      CSR_SOLENOID_HOLD   = 3'd3,
      CSR_RUMBLE_LENGTH   = 3'd4,
      CSR_RUMBLE_STRENGTH = 3'd5,
      CSR_TEMP_WARNING    = 3'd6,
      CSR_TEMP_SHUTDOWN   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_ON_SCREEN  = 2'd0,
      ACT_OFF_SCREEN = 2'd1,
      ACT_RELEASE    = 2'd2,
      ACT_SHUTDOWN   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      TH_SAFE    = 2'd0,
      TH_WARNING = 2'd1,
      TH_FATAL   = 2'd2
   } thermal_type;

   // Which interval a solenoid toggle is timed against.
   typedef enum logic [1:0] {
      IV_ON         = 2'd0,
      IV_OFF        = 2'd1,
      IV_OFF_SCALED = 2'd2
   } interval_type;

   // Thermal monitor status towards the solenoid timing logic.
   typedef struct packed {
      thermal_type class_now;
      thermal_type class_eff;
   } srfc_therm_type;

   // Temperature in degrees: trunc((adc * 330 - 204800) / 4096).
   function automatic logic signed [TempWidth-1:0] temp_from_adc(
      input logic [AdcWidth-1:0] adc
   );
      logic [20:0]        prod;
      logic signed [21:0] diff;
      prod = {9'd0, adc} * 21'd330;
      diff = $signed({1'b0, prod}) - 22'sd204800;
      // Round toward zero for negative values before the shift.
      if (diff < 22'sd0) begin
         diff = diff + 22'sd4095;
      end
      return diff[21:12];
   endfunction

endpackage

`default_nettype wire

>>> hdl/srfc_if.sv
// ----------------------------------------------------------------------------
// Solenoid and rumble feedback controller channels
// Event request channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface srfc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_ms;
   logic        trigger_held;
   logic [11:0] temp_sample;

   modport source (output valid, action, now_ms, trigger_held, temp_sample, input ready);
   modport sink   (input valid, action, now_ms, trigger_held, temp_sample, output ready);
endinterface

interface srfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       solenoid_drive;
   logic [7:0] rumble_drive;
   logic [1:0] thermal_state;
   logic       burst_active;

   modport source (output valid, solenoid_drive, rumble_drive, thermal_state, burst_active,
                   input ready);
   modport sink   (input valid, solenoid_drive, rumble_drive, thermal_state, burst_active,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/solenoid_rumble_feedback_controller_core.sv
// ----------------------------------------------------------------------------
// Solenoid and rumble feedback controller
// Drives a solenoid (single shot, hold-repeat, autofire, burst) and a rumble
// motor from trigger events, with a thermal monitor that throttles or stops
// the solenoid.
//
//   Channel  Direction  Handshake         Content
//   req      in         valid/ready       action, now_ms, trigger_held, temp_sample
//   rsp      out        valid/ready       solenoid_drive, rumble_drive,
//                                         thermal_state, burst_active
//   csr      in         csr_wr_en only    csr_index, csr_wdata
//
// One event per clock is sustained while the result is taken; a request is
// loaded into the input register, then its result into the result register,
// where it is valid. The state update and all timing compares are combinational
// between the input register and the result register.
// Reset is synchronous and clears the valid flags and controller state; registers take their defaults.
// A stalled result holds the pipeline; a new request is still taken while the
// input register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module solenoid_rumble_feedback_controller_core
   import srfc_pkg::*;
#(
   parameter int unsigned BURST_SHOTS = BurstShotsDefault
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   srfc_req_if.sink                      req,
   srfc_rsp_if.source                    rsp,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int unsigned ShotWidth = $clog2(BURST_SHOTS + 2);
   localparam logic [ShotWidth-1:0] ShotLimit = ShotWidth'(BURST_SHOTS + 1);
   localparam logic [ShotWidth-1:0] ShotOne   = ShotWidth'(1);

   // Configuration registers.
   logic [FlagsWidth-1:0]        flags_ff;
   logic [MsWidth-1:0]           sol_on_ff;
   logic [MsWidth-1:0]           sol_off_ff;
   logic [MsWidth-1:0]           sol_hold_ff;
   logic [MsWidth-1:0]           rum_len_ff;
   logic [LevelWidth-1:0]        rum_strength_ff;
   logic signed [TempWidth-1:0]  temp_warn_ff;
   logic signed [TempWidth-1:0]  temp_shut_ff;

   // Input register.
   logic                         s1_valid_ff;
   action_type                   s1_action_ff;
   logic [TimeWidth-1:0]         s1_now_ff;
   logic                         s1_held_ff;
   logic signed [TempWidth-1:0]  s1_temp_ff;

   // Controller state.
   logic                         sol_level_ff,   sol_level_in;
   logic [TimeWidth-1:0]         sol_mark_ff,    sol_mark_in;
   logic                         first_shot_ff,  first_shot_in;
   logic                         burst_run_ff,   burst_run_in;
   logic [ShotWidth-1:0]         shots_ff,       shots_in;
   logic [ShotWidth-1:0]         synced_ff,      synced_in;
   logic [LevelWidth-1:0]        rum_level_ff,   rum_level_in;
   logic [TimeWidth-1:0]         rum_mark_ff,    rum_mark_in;
   logic                         rum_run_ff,     rum_run_in;
   logic                         rum_done_ff,    rum_done_in;

   // Result register.
   logic                         rsp_valid_ff;
   logic                         rsp_sol_ff;
   logic [LevelWidth-1:0]        rsp_rum_ff;
   thermal_type                  rsp_class_ff;
   logic                         rsp_burst_ff;

   logic                         fire;
   logic                         req_ready;
   logic                         do_burst;
   logic                         sol_act;
   logic                         sol_fs;
   interval_type                 sol_iv;
   logic                         rum_act;
   logic                         therm_attempt;
   logic                         el_ge_iv;
   logic                         rum_end;
   thermal_type                  class_out;
   srfc_therm_type               therm;

   logic [TimeWidth-1:0]         sol_el;
   logic [TimeWidth-1:0]         rum_el;
   logic [TimeWidth-1:0]         off_scaled;
   logic                         el_ge_on;
   logic                         el_ge_off;
   logic                         el_ge_off_scaled;
   logic                         el_ge_hold;
   logic                         el_ge_warn;

   // Handshake: the event is processed when the result register is free.
   assign fire      = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req_ready = !s1_valid_ff || fire;
   assign req.ready = req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff        <= ResetFlags;
         sol_on_ff       <= ResetSolenoidOn;
         sol_off_ff      <= ResetSolenoidOff;
         sol_hold_ff     <= ResetSolenoidHold;
         rum_len_ff      <= ResetRumbleLength;
         rum_strength_ff <= ResetRumbleLevel;
         temp_warn_ff    <= ResetTempWarning;
         temp_shut_ff    <= ResetTempShutdown;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FEATURE_FLAGS:   flags_ff        <= csr_wdata[FlagsWidth-1:0];
            CSR_SOLENOID_ON:     sol_on_ff       <= csr_wdata[MsWidth-1:0];
            CSR_SOLENOID_OFF:    sol_off_ff      <= csr_wdata[MsWidth-1:0];
            CSR_SOLENOID_HOLD:   sol_hold_ff     <= csr_wdata[MsWidth-1:0];
            CSR_RUMBLE_LENGTH:   rum_len_ff      <= csr_wdata[MsWidth-1:0];
            CSR_RUMBLE_STRENGTH: rum_strength_ff <= csr_wdata[LevelWidth-1:0];
            CSR_TEMP_WARNING:    temp_warn_ff    <= csr_wdata[TempWidth-1:0];
            CSR_TEMP_SHUTDOWN:   temp_shut_ff    <= csr_wdata[TempWidth-1:0];
         endcase
      end
   end

   // Input register; the ADC sample is converted to degrees on the way in.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req.valid) begin
         s1_action_ff <= action_type'(req.action);
         s1_now_ff    <= req.now_ms;
         s1_held_ff   <= req.trigger_held;
         s1_temp_ff   <= temp_from_adc(req.temp_sample);
      end
   end

   // Elapsed times and interval compares, all in parallel.
   assign sol_el     = s1_now_ff - sol_mark_ff;
   assign rum_el     = s1_now_ff - rum_mark_ff;
   assign off_scaled = flags_ff[FlagDoubleOff] ? {15'd0, sol_off_ff, 1'b0}
                                               : {16'd0, sol_off_ff};

   assign el_ge_on         = sol_el >= {16'd0, sol_on_ff};
   assign el_ge_off        = sol_el >= {16'd0, sol_off_ff};
   assign el_ge_off_scaled = sol_el >= off_scaled;
   assign el_ge_hold       = sol_el >= {16'd0, sol_hold_ff};
   assign el_ge_warn       = sol_el >= {14'd0, sol_off_ff, 2'b00};

   // Rumble pulse end, halved length in rumble-as-feedback mode, where autofire keeps it running.
   always_comb begin
      if (flags_ff[FlagRumbleFb]) begin
         rum_end = !flags_ff[FlagAutofire] && (rum_el >= {17'd0, rum_len_ff[MsWidth-1:1]});
      end else begin
         rum_end = rum_el >= {16'd0, rum_len_ff};
      end
   end

   // Thermal monitor.
   srfc_thermal u_thermal (
      .clock      (clock),
      .reset      (reset),
      .now_ms     (s1_now_ff),
      .temp_c     (s1_temp_ff),
      .warning_c  (temp_warn_ff),
      .shutdown_c (temp_shut_ff),
      .attempt    (therm_attempt),
      .status     (therm)
   );

   // Event decoding and next state.
   always_comb begin
      sol_level_in  = sol_level_ff;
      sol_mark_in   = sol_mark_ff;
      first_shot_in = first_shot_ff;
      burst_run_in  = burst_run_ff;
      shots_in      = shots_ff;
      synced_in     = synced_ff;
      rum_level_in  = rum_level_ff;
      rum_mark_in   = rum_mark_ff;
      rum_run_in    = rum_run_ff;
      rum_done_in   = rum_done_ff;
      do_burst      = 1'b0;
      sol_act       = 1'b0;
      sol_fs        = first_shot_ff;
      sol_iv        = IV_ON;
      rum_act       = 1'b0;
      therm_attempt = 1'b0;
      el_ge_iv      = 1'b0;

      if (fire) begin
         unique case (s1_action_ff)
            ACT_ON_SCREEN: begin
               if (flags_ff[FlagSolenoid]) begin
                  if (!s1_held_ff) begin
                     // Fresh pull: first shot fires at once.
                     if (flags_ff[FlagBurst] && !burst_run_ff) begin
                        sol_act       = 1'b1;
                        sol_fs        = 1'b1;
                        first_shot_in = 1'b0;
                        burst_run_in  = 1'b1;
                        shots_in      = ShotOne;
                        synced_in     = ShotOne;
                     end else if (!flags_ff[FlagBurst]) begin
                        sol_act       = 1'b1;
                        sol_fs        = 1'b1;
                        first_shot_in = !flags_ff[FlagAutofire];
                     end
                  end else if (burst_run_ff) begin
                     do_burst = 1'b1;
                  end else if (flags_ff[FlagAutofire] && !flags_ff[FlagBurst]) begin
                     sol_act = 1'b1;
                     sol_iv  = sol_level_ff ? IV_ON : IV_OFF_SCALED;
                  end else if (first_shot_ff) begin
                     // Single shot held: end the pulse, then wait the hold time.
                     if (sol_level_ff) begin
                        if (el_ge_on) begin
                           sol_level_in = 1'b0;
                        end
                     end else if (el_ge_hold) begin
                        sol_act       = 1'b1;
                        sol_fs        = 1'b1;
                        first_shot_in = 1'b0;
                     end
                  end else if (!flags_ff[FlagBurst]) begin
                     sol_act = 1'b1;
                     sol_iv  = sol_level_ff ? IV_ON : IV_OFF;
                  end
               end else if (flags_ff[FlagRumble] && flags_ff[FlagRumbleFb] &&
                            !rum_done_ff && !s1_held_ff) begin
                  rum_act = 1'b1;
               end
               if (flags_ff[FlagRumble] && rum_run_ff && s1_held_ff) begin
                  rum_act = 1'b1;
               end
            end
            ACT_OFF_SCREEN: begin
               if (flags_ff[FlagRumble]) begin
                  if (!flags_ff[FlagRumbleFb] && !rum_done_ff && !s1_held_ff) begin
                     rum_act = 1'b1;
                  end else if (rum_run_ff) begin
                     rum_act = 1'b1;
                  end
               end
               if (burst_run_ff) begin
                  do_burst = 1'b1;
               end else if (sol_level_ff && !flags_ff[FlagBurst]) begin
                  sol_act = 1'b1;
                  sol_iv  = IV_ON;
               end
            end
            ACT_RELEASE: begin
               if (flags_ff[FlagSolenoid]) begin
                  if (burst_run_ff) begin
                     do_burst = 1'b1;
                  end else if (!flags_ff[FlagBurst] && sol_level_ff) begin
                     first_shot_in = 1'b0;
                     if (el_ge_on) begin
                        sol_mark_in  = s1_now_ff;
                        sol_level_in = 1'b0;
                     end
                  end
               end
               if (flags_ff[FlagRumbleFb] && flags_ff[FlagAutofire]) begin
                  if (rum_run_ff || rum_done_ff) begin
                     rum_level_in = '0;
                     rum_run_in   = 1'b0;
                     rum_done_in  = 1'b0;
                  end
               end else if (rum_run_ff) begin
                  rum_act = 1'b1;
               end else if (rum_done_ff) begin
                  rum_done_in = 1'b0;
               end
            end
            ACT_SHUTDOWN: begin
               sol_level_in  = 1'b0;
               rum_level_in  = '0;
               first_shot_in = 1'b0;
               rum_run_in    = 1'b0;
               rum_done_in   = 1'b0;
               burst_run_in  = 1'b0;
               shots_in      = '0;
            end
         endcase
      end

      // Burst step: count shots on each release edge, stop past the limit.
      if (do_burst) begin
         if (shots_ff < ShotLimit) begin
            if (!sol_level_ff && shots_ff == synced_ff) begin
               shots_in = shots_ff + ShotOne;
            end
            sol_act = 1'b1;
            if (!sol_level_ff) begin
               sol_iv = IV_OFF_SCALED;
            end else begin
               synced_in = shots_ff;
               sol_iv    = IV_ON;
            end
         end else begin
            burst_run_in = 1'b0;
            shots_in     = '0;
         end
      end

      unique case (sol_iv)
         IV_ON:         el_ge_iv = el_ge_on;
         IV_OFF:        el_ge_iv = el_ge_off;
         IV_OFF_SCALED: el_ge_iv = el_ge_off_scaled;
         default:       el_ge_iv = el_ge_on;
      endcase

      // Solenoid activation with thermal throttling.
      if (sol_act) begin
         if (sol_fs) begin
            sol_mark_in  = s1_now_ff;
            sol_level_in = 1'b1;
         end else if (flags_ff[FlagTempSensor]) begin
            therm_attempt = 1'b1;
            if (therm.class_eff == TH_FATAL) begin
               sol_level_in = 1'b0;
            end else if (therm.class_eff == TH_WARNING && !sol_level_ff) begin
               if (el_ge_warn) begin
                  sol_mark_in  = s1_now_ff;
                  sol_level_in = 1'b1;
               end
            end else if (el_ge_iv) begin
               sol_mark_in  = s1_now_ff;
               sol_level_in = !sol_level_ff;
            end
         end else if (el_ge_iv) begin
            sol_mark_in  = s1_now_ff;
            sol_level_in = !sol_level_ff;
         end
      end

      // Rumble activation: start a pulse, or end a running one when timed out.
      if (rum_act) begin
         if (rum_run_ff) begin
            if (rum_end) begin
               rum_level_in = '0;
               rum_run_in   = 1'b0;
               rum_done_in  = 1'b1;
            end
         end else begin
            rum_mark_in  = s1_now_ff;
            rum_level_in = rum_strength_ff;
            rum_run_in   = 1'b1;
         end
      end
   end

   assign class_out = therm_attempt ? therm.class_eff : therm.class_now;

   // State registers; next values equal current ones unless an event fires.
   always_ff @(posedge clock) begin
      if (reset) begin
         sol_level_ff  <= 1'b0;
         sol_mark_ff   <= '0;
         first_shot_ff <= 1'b0;
         burst_run_ff  <= 1'b0;
         shots_ff      <= '0;
         synced_ff     <= '0;
         rum_level_ff  <= '0;
         rum_mark_ff   <= '0;
         rum_run_ff    <= 1'b0;
         rum_done_ff   <= 1'b0;
      end else begin
         sol_level_ff  <= sol_level_in;
         sol_mark_ff   <= sol_mark_in;
         first_shot_ff <= first_shot_in;
         burst_run_ff  <= burst_run_in;
         shots_ff      <= shots_in;
         synced_ff     <= synced_in;
         rum_level_ff  <= rum_level_in;
         rum_mark_ff   <= rum_mark_in;
         rum_run_ff    <= rum_run_in;
         rum_done_ff   <= rum_done_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_sol_ff   <= sol_level_in;
         rsp_rum_ff   <= rum_level_in;
         rsp_class_ff <= class_out;
         rsp_burst_ff <= burst_run_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.solenoid_drive = rsp_sol_ff;
   assign rsp.rumble_drive   = rsp_rum_ff;
   assign rsp.thermal_state  = rsp_class_ff;
   assign rsp.burst_active   = rsp_burst_ff;

   // A shutdown event always reports everything off.
   a_shutdown_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_action_ff == ACT_SHUTDOWN) |=>
      (!rsp_sol_ff && rsp_rum_ff == '0 && !rsp_burst_ff))
      else $error("shutdown result not cleared");

   // The burst shot counter never passes its end count.
   a_burst_bound: assert property (@(posedge clock) disable iff (reset)
      shots_ff <= ShotLimit)
      else $error("burst shot counter out of range");

   // The rumble motor is only driven while a pulse is running.
   a_rumble_running: assert property (@(posedge clock) disable iff (reset)
      (rum_level_ff != '0) |-> rum_run_ff)
      else $error("rumble driven without a running pulse");

   // An event held in the input register is not dropped while the result stalls.
   a_event_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fire) |=> (s1_valid_ff && $stable(s1_now_ff)))
      else $error("pending event lost");

endmodule

`default_nettype wire

>>> hdl/srfc_thermal.sv
// ----------------------------------------------------------------------------
// Thermal monitor
// Takes one sample per interval, averages four and classifies the temperature
// as safe, warning or fatal with hysteresis below each threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module srfc_thermal
   import srfc_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [TimeWidth-1:0]        now_ms,
   input  wire logic signed [TempWidth-1:0] temp_c,
   input  wire logic signed [TempWidth-1:0] warning_c,
   input  wire logic signed [TempWidth-1:0] shutdown_c,
   input  wire logic                        attempt,
   output srfc_therm_type                   status
);

   logic [TimeWidth-1:0]        mark_ff;
   logic [TimeWidth-1:0]        mark_in;
   logic [1:0]                  slot_ff;
   logic [1:0]                  slot_in;
   logic signed [TempWidth:0]   psum_ff;
   logic signed [TempWidth:0]   psum_in;
   thermal_type                 class_ff;
   thermal_type                 class_in;

   logic [TimeWidth-1:0]        elapsed;
   logic                        due;
   logic [TempWidth+1:0]        sum;
   logic signed [TempWidth-1:0] avg;
   logic signed [TempWidth:0]   avg_x;
   logic signed [TempWidth:0]   warn_x;
   logic signed [TempWidth:0]   shut_x;
   logic signed [TempWidth:0]   warn_lo;
   logic signed [TempWidth:0]   shut_lo;
   thermal_type                 class_new;

   // A sample is due once more than the interval has passed.
   assign elapsed = now_ms - mark_ff;
   assign due     = elapsed > TimeWidth'(SampleIntervalMs);

   // Sum of the three stored samples and the new one, floored divide by four.
   assign sum   = {psum_ff[TempWidth], psum_ff} + {{2{temp_c[TempWidth-1]}}, temp_c};
   assign avg   = sum[TempWidth+1:2];
   assign avg_x = {avg[TempWidth-1], avg};

   assign warn_x  = {warning_c[TempWidth-1], warning_c};
   assign shut_x  = {shutdown_c[TempWidth-1], shutdown_c};
   assign warn_lo = warn_x - Hysteresis;
   assign shut_lo = shut_x - Hysteresis;

   // Classification of the new average against the current class.
   always_comb begin
      unique case (class_ff)
         TH_FATAL: begin
            class_new = (avg_x < shut_lo) ? TH_WARNING : TH_FATAL;
         end
         TH_WARNING: begin
            if (avg_x >= shut_x) begin
               class_new = TH_FATAL;
            end else if (avg_x < warn_lo) begin
               class_new = TH_SAFE;
            end else begin
               class_new = TH_WARNING;
            end
         end
         TH_SAFE: begin
            if (avg_x >= shut_x) begin
               class_new = TH_FATAL;
            end else if (avg_x >= warn_x) begin
               class_new = TH_WARNING;
            end else begin
               class_new = TH_SAFE;
            end
         end
         default: begin
            class_new = class_ff;
         end
      endcase
   end

   // Class as it stands after a sample attempt in this cycle.
   assign status.class_now = class_ff;
   assign status.class_eff = (due && slot_ff == 2'd3) ? class_new : class_ff;

   // Sample history update: the partial sum stands in for the first three slots.
   always_comb begin
      mark_in  = mark_ff;
      slot_in  = slot_ff;
      psum_in  = psum_ff;
      class_in = class_ff;
      if (attempt && due) begin
         mark_in = now_ms;
         if (slot_ff == 2'd3) begin
            slot_in  = 2'd0;
            class_in = class_new;
         end else begin
            slot_in = slot_ff + 2'd1;
            if (slot_ff == 2'd0) begin
               psum_in = {temp_c[TempWidth-1], temp_c};
            end else begin
               psum_in = psum_ff + {temp_c[TempWidth-1], temp_c};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff  <= '0;
         slot_ff  <= 2'd0;
         class_ff <= TH_SAFE;
      end else begin
         mark_ff  <= mark_in;
         slot_ff  <= slot_in;
         class_ff <= class_in;
      end
   end

   // Partial sum is always rewritten at slot zero before it is read.
   always_ff @(posedge clock) begin
      psum_ff <= psum_in;
   end

endmodule

`default_nettype wire

>>> tb/srfc_test_pkg.sv
// ----------------------------------------------------------------------------
// Feedback controller scoreboard
// Predicts the solenoid, rumble, thermal and burst outputs of the feedback
// controller for every accepted event, and checks each result transfer
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

package srfc_test_pkg;
   import srfc_pkg::*;

   // One result as it leaves the block.
   typedef struct packed {
      logic       solenoid;
      logic [7:0] rumble;
      logic [1:0] thermal;
      logic       burst;
   } drive_state_type;

   class feedback_scoreboard;
      // Register copies.
      bit [6:0]    flags;
      bit [31:0]   on_ms, off_ms, hold_ms, rumble_ms;
      bit [7:0]    strength;
      int          warn_c, shut_c;
      // Controller state.
      bit          sol_on, first_shot, burst_on, rumble_on, rumble_spent;
      bit [7:0]    rumble_level;
      int unsigned shots, shots_synced;
      bit [31:0]   sol_mark, rumble_mark, sample_mark, now_ms;
      int          history[4];
      int unsigned slot;
      thermal_type heat_class;
      // Predicted drive states, oldest first.
      drive_state_type expected_drives[$];
      int unsigned mismatches;

      function new();
         flags      = ResetFlags;
         on_ms      = ResetSolenoidOn;
         off_ms     = ResetSolenoidOff;
         hold_ms    = ResetSolenoidHold;
         rumble_ms  = ResetRumbleLength;
         strength   = ResetRumbleLevel;
         warn_c     = $signed(ResetTempWarning);
         shut_c     = $signed(ResetTempShutdown);
         heat_class = TH_SAFE;
         mismatches = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] value);
         case (idx)
            CSR_FEATURE_FLAGS:   flags = value[6:0];
            CSR_SOLENOID_ON:     on_ms = value;
            CSR_SOLENOID_OFF:    off_ms = value;
            CSR_SOLENOID_HOLD:   hold_ms = value;
            CSR_RUMBLE_LENGTH:   rumble_ms = value;
            CSR_RUMBLE_STRENGTH: strength = value[7:0];
            CSR_TEMP_WARNING:    warn_c = $signed(value[9:0]);
            CSR_TEMP_SHUTDOWN:   shut_c = $signed(value[9:0]);
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_drives.size();
      endfunction

      // One thermal sample per interval; every fourth sample the average is
      // classified, with hysteresis below each threshold.
      function void take_sample(logic [11:0] adc);
         bit [31:0] gap;
         int        degrees, mean;
         gap = now_ms - sample_mark;
         if (gap <= SampleIntervalMs) return;
         sample_mark = now_ms;
         degrees = adc;
         degrees = (degrees * 330 - 204800) / 4096;
         history[slot] = degrees;
         if (slot < 3) begin
            slot++;
            return;
         end
         slot = 0;
         mean = (history[0] + history[1] + history[2] + history[3]) >>> 2;
         if (heat_class == TH_FATAL) begin
            if (mean < shut_c - 5) heat_class = TH_WARNING;
         end else if (mean >= shut_c) begin
            heat_class = TH_FATAL;
         end else if (heat_class == TH_WARNING) begin
            if (mean < warn_c - 5) heat_class = TH_SAFE;
         end else if (mean >= warn_c) begin
            heat_class = TH_WARNING;
         end
      endfunction

      function void toggle_after(bit [31:0] interval);
         bit [31:0] gap;
         gap = now_ms - sol_mark;
         if (gap >= interval) begin
            sol_mark = now_ms;
            sol_on   = !sol_on;
         end
      endfunction

      // Solenoid timing step, throttled or stopped by the thermal class.
      function void energise(bit [31:0] interval, logic [11:0] adc);
         if (first_shot) begin
            sol_mark = now_ms;
            sol_on   = 1'b1;
         end else if (flags[FlagTempSensor]) begin
            take_sample(adc);
            if (heat_class == TH_FATAL) sol_on = 1'b0;
            else if (heat_class == TH_WARNING && !sol_on) toggle_after(off_ms << 2);
            else toggle_after(interval);
         end else begin
            toggle_after(interval);
         end
      endfunction

      function bit [31:0] off_interval();
         return flags[FlagDoubleOff] ? off_ms << 1 : off_ms;
      endfunction

      function void run_rumble();
         bit [31:0] gap;
         bit        stop;
         if (rumble_on) begin
            gap = now_ms - rumble_mark;
            if (flags[FlagRumbleFb]) stop = !flags[FlagAutofire] && gap >= (rumble_ms >> 1);
            else stop = gap >= rumble_ms;
            if (stop) begin
               rumble_level = 8'd0;
               rumble_on    = 1'b0;
               rumble_spent = 1'b1;
            end
         end else begin
            rumble_mark  = now_ms;
            rumble_level = strength;
            rumble_on    = 1'b1;
         end
      endfunction

      // A burst counts its shots and ends one step after the last one.
      function void burst_step(logic [11:0] adc);
         if (shots < BurstShotsDefault + 1) begin
            if (!sol_on && shots == shots_synced) shots++;
            if (!sol_on) begin
               energise(off_interval(), adc);
            end else begin
               shots_synced = shots;
               energise(on_ms, adc);
            end
         end else begin
            burst_on = 1'b0;
            shots    = 0;
         end
      endfunction

      function void on_screen(bit held, logic [11:0] adc);
         bit [31:0] gap;
         gap = now_ms - sol_mark;
         if (flags[FlagSolenoid]) begin
            if (!held) begin
               if (flags[FlagBurst] && !burst_on) begin
                  first_shot = 1'b1;
                  energise(0, adc);
                  first_shot   = 1'b0;
                  burst_on     = 1'b1;
                  shots        = 1;
                  shots_synced = 1;
               end else if (!flags[FlagBurst]) begin
                  first_shot = 1'b1;
                  energise(0, adc);
                  if (flags[FlagAutofire]) first_shot = 1'b0;
               end
            end else if (burst_on) begin
               burst_step(adc);
            end else if (flags[FlagAutofire] && !flags[FlagBurst]) begin
               energise(sol_on ? on_ms : off_interval(), adc);
            end else if (first_shot) begin
               // Single shot: the pulse ends, then a held trigger repeats after the hold.
               if (sol_on) begin
                  if (gap >= on_ms) sol_on = 1'b0;
               end else if (gap >= hold_ms) begin
                  energise(0, adc);
                  first_shot = 1'b0;
               end
            end else if (!flags[FlagBurst]) begin
               energise(sol_on ? on_ms : off_ms, adc);
            end
         end else if (flags[FlagRumble] && flags[FlagRumbleFb] && !rumble_spent && !held) begin
            run_rumble();
         end
         if (flags[FlagRumble] && rumble_on && held) run_rumble();
      endfunction

      // Off screen the solenoid is timed off even with its feature bit clear.
      function void off_screen(bit held, logic [11:0] adc);
         if (flags[FlagRumble]) begin
            if (!flags[FlagRumbleFb] && !rumble_spent && !held) run_rumble();
            else if (rumble_on) run_rumble();
         end
         if (burst_on) burst_step(adc);
         else if (sol_on && !flags[FlagBurst]) energise(on_ms, adc);
      endfunction

      function void let_go(logic [11:0] adc);
         bit [31:0] gap;
         gap = now_ms - sol_mark;
         if (flags[FlagSolenoid]) begin
            if (burst_on) begin
               burst_step(adc);
            end else if (!flags[FlagBurst] && sol_on) begin
               first_shot = 1'b0;
               if (gap >= on_ms) begin
                  sol_mark = now_ms;
                  sol_on   = 1'b0;
               end
            end
         end
         if (flags[FlagRumbleFb] && flags[FlagAutofire]) begin
            if (rumble_on || rumble_spent) begin
               rumble_level = 8'd0;
               rumble_on    = 1'b0;
               rumble_spent = 1'b0;
            end
         end else if (rumble_on) begin
            run_rumble();
         end else if (rumble_spent) begin
            rumble_spent = 1'b0;
         end
      endfunction

      // Called for every event transfer; queues the drive state it leads to.
      function void note_event(action_type act, logic [31:0] stamp, logic held,
                               logic [11:0] adc);
         drive_state_type want;
         now_ms = stamp;
         case (act)
            ACT_ON_SCREEN:  on_screen(held, adc);
            ACT_OFF_SCREEN: off_screen(held, adc);
            ACT_RELEASE:    let_go(adc);
            default: begin
               // Shutdown keeps the synced shot count and the thermal class.
               sol_on       = 1'b0;
               rumble_level = 8'd0;
               first_shot   = 1'b0;
               rumble_on    = 1'b0;
               rumble_spent = 1'b0;
               burst_on     = 1'b0;
               shots        = 0;
            end
         endcase
         want.solenoid = sol_on;
         want.rumble   = rumble_level;
         want.thermal  = heat_class;
         want.burst    = burst_on;
         expected_drives.push_back(want);
      endfunction

      function void check_result(drive_state_type got);
         drive_state_type want;
         if (expected_drives.size() == 0) begin
            $error("result with no event waiting: solenoid %0d rumble %0d thermal %0d burst %0d",
                   got.solenoid, got.rumble, got.thermal, got.burst);
            mismatches++;
            return;
         end
         want = expected_drives.pop_front();
         if (got.solenoid !== want.solenoid) begin
            $error("solenoid_drive: expected %0d, actual %0d", want.solenoid, got.solenoid);
            mismatches++;
         end
         if (got.rumble !== want.rumble) begin
            $error("rumble_drive: expected %0d, actual %0d", want.rumble, got.rumble);
            mismatches++;
         end
         if (got.thermal !== want.thermal) begin
            $error("thermal_state: expected %0d, actual %0d", want.thermal, got.thermal);
            mismatches++;
         end
         if (got.burst !== want.burst) begin
            $error("burst_active: expected %0d, actual %0d", want.burst, got.burst);
            mismatches++;
         end
      endfunction
   endclass

endpackage

`default_nettype wire

>>> tb/solenoid_rumble_feedback_controller_core_test.sv
// ----------------------------------------------------------------------------
// Feedback controller testbench
// Drives directed and random trigger events through the feedback controller
// under several register settings, with random gaps on both channels, a long
// result stall and a full drain, and checks every result against the
// scoreboard's prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module solenoid_rumble_feedback_controller_core_test;
   import srfc_pkg::*;
   import srfc_test_pkg::*;

   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned HoldOffCycles = 80;
   localparam int unsigned IdlePercent   = 21;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   srfc_req_if req_bus ();
   srfc_rsp_if rsp_bus ();

   feedback_scoreboard drive_book;

   // Shared between the sender and the receiver.
   bit          calm;
   bit          hold_off_request;
   // Event generator state.
   bit [31:0]   event_ms;
   bit          pressed;
   int          heat_adc;
   int unsigned cycles;

   solenoid_rumble_feedback_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CycleLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Result side: random stalls, one long hold-off, checks at the
   // falling edge before each transfer edge.
   initial begin
      int unsigned     hold_left;
      drive_state_type got;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = HoldOffCycles;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || $urandom_range(0, 99) >= IdlePercent;
         end
         @(negedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.solenoid = rsp_bus.solenoid_drive;
            got.rumble   = rsp_bus.rumble_drive;
            got.thermal  = rsp_bus.thermal_state;
            got.burst    = rsp_bus.burst_active;
            drive_book.check_result(got);
         end
      end
   end

   // Offers one event and waits for its transfer.
   task automatic offer(action_type act, bit [31:0] stamp, bit held, bit [11:0] adc);
      bit taken;
      while (!calm && $urandom_range(0, 99) < IdlePercent) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.now_ms       <= stamp;
      req_bus.trigger_held <= held;
      req_bus.temp_sample  <= adc;
      do begin
         @(negedge clock);
         taken = req_bus.ready === 1'b1;
         @(posedge clock);
      end while (!taken);
      drive_book.note_event(act, stamp, held, adc);
   endtask

   // Stops offering until every predicted result has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (drive_book.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, bit [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      drive_book.set_register(idx, value);
   endtask

   // Writes every register once the block is idle, and centres the
   // temperature drift on the warning threshold.
   task automatic apply_settings(bit [6:0] flags, bit [15:0] on_ms, bit [15:0] off_ms,
                                 bit [15:0] hold_ms, bit [15:0] rumble_ms,
                                 bit [7:0] strength, int warn_c, int shut_c);
      drain();
      write_csr(CSR_FEATURE_FLAGS, 16'(flags));
      write_csr(CSR_SOLENOID_ON, on_ms);
      write_csr(CSR_SOLENOID_OFF, off_ms);
      write_csr(CSR_SOLENOID_HOLD, hold_ms);
      write_csr(CSR_RUMBLE_LENGTH, rumble_ms);
      write_csr(CSR_RUMBLE_STRENGTH, 16'(strength));
      write_csr(CSR_TEMP_WARNING, 16'(warn_c));
      write_csr(CSR_TEMP_SHUTDOWN, 16'(shut_c));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      heat_adc = ((warn_c + 50) * 4096) / 330;
      if (heat_adc > 4095) heat_adc = 4095;
   endtask

   function automatic bit [15:0] pick_ms(int unsigned span);
      if ($urandom_range(0, 99) < 10) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(0, span));
   endfunction

   // Mostly press, hold and release sequences on a rising clock of
   // milliseconds, with some noise events mixed in.
   task automatic random_events(int unsigned count);
      int unsigned roll;
      action_type  act;
      bit          held;
      bit [11:0]   adc;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 55) event_ms += $urandom_range(0, 20);
         else if (roll < 85) event_ms += $urandom_range(20, 150);
         else if (roll < 96) event_ms += $urandom_range(0, 3);
         else event_ms += $urandom;

         roll = $urandom_range(0, 99);
         held = 1'b0;
         if (!pressed) begin
            if (roll < 55) begin
               act     = ACT_ON_SCREEN;
               pressed = 1'b1;
            end else if (roll < 75) begin
               act     = ACT_OFF_SCREEN;
               pressed = 1'b1;
            end else if (roll < 88) begin
               act = ACT_RELEASE;
            end else if (roll < 93) begin
               act = ACT_SHUTDOWN;
            end else begin
               act  = action_type'($urandom_range(0, 3));
               held = 1'($urandom_range(0, 1));
            end
         end else begin
            held = 1'b1;
            if (roll < 60) begin
               act = ACT_ON_SCREEN;
            end else if (roll < 75) begin
               act = ACT_OFF_SCREEN;
            end else if (roll < 91) begin
               act     = ACT_RELEASE;
               held    = 1'b0;
               pressed = 1'b0;
            end else if (roll < 94) begin
               act     = ACT_SHUTDOWN;
               held    = 1'b0;
               pressed = 1'b0;
            end else begin
               act  = action_type'($urandom_range(0, 3));
               held = 1'($urandom_range(0, 1));
            end
         end

         // Temperature drifts slowly, with the odd wild or extreme reading.
         heat_adc += int'($urandom_range(0, 120)) - 60;
         if (heat_adc < 0) heat_adc = 0;
         if (heat_adc > 4095) heat_adc = 4095;
         roll = $urandom_range(0, 99);
         if (roll < 4) adc = 12'($urandom);
         else if (roll == 4) adc = 12'd0;
         else if (roll == 5) adc = 12'hFFF;
         else adc = 12'(heat_adc);

         offer(act, event_ms, held, adc);
      end
   endtask

   initial begin
      bit [6:0]    flags;
      int          warn_c, shut_c;
      int unsigned phase;
      drive_book = new();
      calm             = 1'b0;
      hold_off_request = 1'b0;
      event_ms         = 32'd0;
      pressed          = 1'b0;
      heat_adc         = 1200;
      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= CSR_FEATURE_FLAGS;
      csr_wdata            <= 16'd0;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_ON_SCREEN;
      req_bus.now_ms       <= 32'd0;
      req_bus.trigger_held <= 1'b0;
      req_bus.temp_sample  <= 12'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: every feature off.
      offer(ACT_ON_SCREEN, 32'd0, 1'b0, 12'd0);

      // Single shot, hold-repeat, rumble pulse and heating to fatal then cooling.
      apply_settings(7'(1 << FlagSolenoid | 1 << FlagRumble | 1 << FlagTempSensor),
                     16'd10, 16'd20, 16'd50, 16'd30, 8'd200, 42, 50);
      offer(ACT_ON_SCREEN,  32'd100, 1'b0, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd105, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd111, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd170, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd181, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd186, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd200, 1'b1, 12'hFFF);
      offer(ACT_ON_SCREEN,  32'd210, 1'b1, 12'hFFF);
      offer(ACT_OFF_SCREEN, 32'd220, 1'b0, 12'd0);
      offer(ACT_OFF_SCREEN, 32'd260, 1'b1, 12'd0);
      offer(ACT_RELEASE,    32'd270, 1'b0, 12'd0);
      offer(ACT_ON_SCREEN,  32'd280, 1'b1, 12'd0);
      offer(ACT_ON_SCREEN,  32'd290, 1'b1, 12'd0);
      offer(ACT_ON_SCREEN,  32'd300, 1'b1, 12'd0);
      offer(ACT_ON_SCREEN,  32'd310, 1'b1, 12'd0);
      offer(ACT_SHUTDOWN,   32'd320, 1'b0, 12'd0);

      // Burst with the doubled off wait, across the wrap of the millisecond clock.
      apply_settings(7'(1 << FlagSolenoid | 1 << FlagBurst | 1 << FlagDoubleOff),
                     16'd10, 16'd80, 16'd50, 16'd30, 8'd200, 42, 50);
      offer(ACT_ON_SCREEN,  32'hFFFF_FFF8, 1'b0, 12'h800);
      offer(ACT_ON_SCREEN,  32'h0000_0030, 1'b1, 12'h7FF);
      offer(ACT_ON_SCREEN,  32'h0000_0100, 1'b1, 12'h800);
      offer(ACT_ON_SCREEN,  32'h0000_0200, 1'b1, 12'h7FF);
      offer(ACT_ON_SCREEN,  32'h0000_0300, 1'b1, 12'h800);
      offer(ACT_OFF_SCREEN, 32'h0000_0400, 1'b1, 12'h800);

      // An energised solenoid is timed off off-screen with its feature bit clear.
      apply_settings(7'(1 << FlagSolenoid), 16'd10, 16'd80, 16'd50, 16'd30, 8'd200, 42, 50);
      offer(ACT_ON_SCREEN, 32'h0000_0500, 1'b0, 12'h400);
      apply_settings(7'd0, 16'd10, 16'd80, 16'd50, 16'd30, 8'd200, 42, 50);
      offer(ACT_OFF_SCREEN, 32'h0000_0600, 1'b0, 12'h400);

      // Random phases, the first two at the extremes of every register.
      event_ms = 32'h0000_0700;
      for (phase = 0; phase < 10; phase++) begin
         if (phase == 0) begin
            apply_settings(7'h7F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 280, 280);
         end else if (phase == 1) begin
            apply_settings(7'h7F, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, -50, -50);
         end else begin
            flags = 7'($urandom_range(0, 127));
            if ($urandom_range(0, 99) < 70) flags[FlagSolenoid] = 1'b1;
            warn_c = int'($urandom_range(0, 330)) - 50;
            if ($urandom_range(0, 99) < 80) begin
               shut_c = warn_c + int'($urandom_range(0, 40));
               if (shut_c > 280) shut_c = 280;
            end else begin
               shut_c = int'($urandom_range(0, 330)) - 50;
            end
            apply_settings(flags, pick_ms(60), pick_ms(80), pick_ms(200), pick_ms(200),
                           8'($urandom_range(0, 255)), warn_c, shut_c);
         end
         calm = (phase == 3);
         if (phase == 4) begin
            random_events(30);
            hold_off_request = 1'b1;
            random_events(65);
         end else if (phase == 6) begin
            random_events(40);
            drain();
            random_events(55);
         end else begin
            random_events(95);
         end
         calm = 1'b0;
      end

      drain();
      repeat (8) @(posedge clock);
      if (drive_book.mismatches == 0 && drive_book.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
